// ===== rtl/stack_machine_execute_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Stack machine execute unit assertion macros
// Shared macros for the concurrent checks of the execute unit.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset.
`define SMX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smx check failed");

// Next-cycle implication, sampled on clk_i, idle during reset.
`define SMX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smx check failed");

`endif

// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Item types, command and status codes, and shared control types.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

  typedef enum logic [4:0] {
    CMD_PUSH  = 5'd0,
    CMD_POP   = 5'd1,
    CMD_ADD   = 5'd2,
    CMD_SUB   = 5'd3,
    CMD_MUL   = 5'd4,
    CMD_DIV   = 5'd5,
    CMD_POW   = 5'd6,
    CMD_SQRT  = 5'd7,
    CMD_IN    = 5'd8,
    CMD_OUT   = 5'd9,
    CMD_PUSHR = 5'd10,
    CMD_POPR  = 5'd11,
    CMD_JMP   = 5'd12,
    CMD_JB    = 5'd13,
    CMD_JA    = 5'd14,
    CMD_JBE   = 5'd15,
    CMD_JAE   = 5'd16,
    CMD_JE    = 5'd17,
    CMD_CALL  = 5'd18,
    CMD_RET   = 5'd19,
    CMD_NOP   = 5'd20
  } cmd_e;

  localparam logic [4:0] LastCmd = 5'd19;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_BADREG = 3'd4,
    ST_NEGSQ  = 3'd5,
    ST_RSTK   = 3'd6,
    ST_BADTGT = 3'd7
  } status_e;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [31:0] argument;
    logic signed [31:0] in_value;
  } smx_in_t;

  typedef struct packed {
    logic [15:0]        next_ip;
    logic signed [31:0] out_value;
    logic               out_valid;
    logic [2:0]         status;
  } smx_out_t;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] arg;
    logic [31:0] inv;
  } smx_dec_t;

  typedef enum logic [1:0] {
    IOP_DIV  = 2'd0,
    IOP_POW  = 2'd1,
    IOP_SQRT = 2'd2
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_req_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_RDA  = 3'd1,
    BK_EXEC = 3'd2,
    BK_ITER = 3'd3,
    BK_WB   = 3'd4
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/smx_front.sv =====
// ----------------------------------------------------------------------------
// Stack machine front end
// Accepts items, classifies the command and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_front import smx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire smx_in_t  in_item_i,
  output logic          q_valid_o,
  output smx_dec_t      q_item_o,
  input  wire logic     q_pop_i
);

  smx_dec_t   slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  smx_dec_t   dec;

  // Codes past the last command run as a one-word no-op.
  always_comb begin
    dec.cmd = (in_item_i.command > LastCmd) ? CMD_NOP : cmd_e'(in_item_i.command);
    dec.arg = in_item_i.argument;
    dec.inv = in_item_i.in_value;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smx_iter.sv =====
// ----------------------------------------------------------------------------
// Stack machine iterative arithmetic unit
// Signed divide, integer power and square root, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_iter import smx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire iter_req_t   req_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      result_o
);

  logic        busy_q;
  iter_op_e    op_q;
  logic [31:0] x_q, y_q, z_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic        fin;

  logic [32:0] dv_t;
  logic        dv_ge;
  logic [31:0] sq_t;

  // Divide runs a fixed count; power and square root stop when z empties.
  assign fin    = (op_q == IOP_DIV) ? (cnt_q == 6'd0) : (z_q == 32'd0);
  assign done_o = busy_q && fin;

  always_comb begin
    case (op_q)
      IOP_DIV:  result_o = neg_q ? (32'd0 - x_q) : x_q;
      IOP_POW:  result_o = y_q;
      IOP_SQRT: result_o = y_q;
      default:  result_o = y_q;
    endcase
  end

  assign dv_t  = {rem_q[31:0], x_q[31]};
  assign dv_ge = (dv_t >= {1'b0, z_q});
  assign sq_t  = y_q + z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      rem_q <= 33'd0;
      cnt_q <= 6'd32;
      neg_q <= a_i[31] ^ b_i[31];
      case (req_i.op)
        IOP_DIV: begin
          x_q <= a_i[31] ? (32'd0 - a_i) : a_i;
          z_q <= b_i[31] ? (32'd0 - b_i) : b_i;
          y_q <= 32'd0;
        end
        IOP_POW: begin
          x_q <= a_i;
          y_q <= 32'd1;
          // An exponent of zero or below gives one at once.
          z_q <= ($signed(b_i) <= 0) ? 32'd0 : b_i;
        end
        IOP_SQRT: begin
          // Square root works on the top of the stack.
          x_q <= b_i;
          y_q <= 32'd0;
          z_q <= 32'h4000_0000;
        end
        default: begin
          x_q <= a_i;
          y_q <= 32'd0;
          z_q <= 32'd0;
        end
      endcase
    end else if (busy_q && !fin) begin
      case (op_q)
        IOP_DIV: begin
          rem_q <= dv_ge ? (dv_t - {1'b0, z_q}) : dv_t;
          x_q   <= {x_q[30:0], dv_ge};
          cnt_q <= cnt_q - 6'd1;
        end
        IOP_POW: begin
          if (z_q[0]) begin
            y_q <= y_q * x_q;
          end
          x_q <= x_q * x_q;
          z_q <= z_q >> 1;
        end
        IOP_SQRT: begin
          if (x_q >= sq_t) begin
            x_q <= x_q - sq_t;
            y_q <= (y_q >> 1) + z_q;
          end else begin
            y_q <= y_q >> 1;
          end
          z_q <= z_q >> 2;
        end
        default: begin
          z_q <= 32'd0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smx_back.sv =====
// ----------------------------------------------------------------------------
// Stack machine back end
// Holds the machine state, executes queued items and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_back import smx_pkg::*; #(
  parameter int DATA_STACK_DEPTH   = 64,
  parameter int RETURN_STACK_DEPTH = 16,
  parameter int NUM_REGS           = 8,
  parameter int CODE_ADDR_BITS     = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_valid_i,
  input  wire smx_dec_t q_item_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output smx_out_t      out_item_o
);

  localparam int DW  = $clog2(DATA_STACK_DEPTH + 1);
  localparam int AW  = $clog2(DATA_STACK_DEPTH);
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int RAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam int GW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CAB = CODE_ADDR_BITS;

  back_state_e state_q, state_d;

  smx_dec_t       cur_q;
  logic [CAB-1:0] ip_q, ip_d;
  logic [DW-1:0]  dep_q, dep_d, dm1, dm2;
  logic [RDW-1:0] rdep_q, rdep_d, rdm1;
  logic [31:0]    b_q;
  smx_out_t       res_q, res_d;
  smx_out_t       out_q;
  logic           out_vld_q;

  // Storage arrays.
  logic [31:0]    ds_mem [DATA_STACK_DEPTH];
  logic [CAB-1:0] rs_mem [RETURN_STACK_DEPTH];
  logic [31:0]    rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;

  logic [AW-1:0]  ds_raddr, ds_waddr;
  logic [31:0]    ds_rdata_q, ds_wdata;
  logic           ds_we;
  logic [CAB-1:0] rs_rdata_q;
  logic           rs_we;
  logic [31:0]    rf_rdata_q;
  logic           rf_rvld_q;
  logic           rf_we;
  logic [GW-1:0]  rf_idx;

  // Execute decisions.
  status_e        st;
  logic [CAB-1:0] nip, nip1, nip2;
  logic [31:0]    a_val, reg_val, ov;
  logic           ovalid, take, tgt_ok, reg_ok, finish, go_iter;
  logic [63:0]    argx;
  logic [CAB+15:0] ipx;
  iter_req_t      ireq;
  logic           idone;
  logic [31:0]    ires;

  assign dm1    = dep_q - DW'(1);
  assign dm2    = dep_q - DW'(2);
  assign rdm1   = rdep_q - RDW'(1);
  assign nip1   = ip_q + CAB'(1);
  assign nip2   = ip_q + CAB'(2);
  assign a_val  = ds_rdata_q;
  assign rf_idx = cur_q.arg[GW-1:0];
  assign reg_ok = (cur_q.arg < 32'(NUM_REGS));
  assign reg_val = rf_rvld_q ? rf_rdata_q : 32'd0;
  assign argx   = {32'd0, cur_q.arg};
  assign tgt_ok = ((argx >> CODE_ADDR_BITS) == 64'd0);

  // Top of stack is read while the item is taken, the entry below it next.
  assign ds_raddr = (state_q == BK_IDLE) ? dm1[AW-1:0] : dm2[AW-1:0];
  assign q_pop_o  = (state_q == BK_IDLE) && q_valid_i;

  smx_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ireq),
    .a_i      (a_val),
    .b_i      (b_q),
    .done_o   (idone),
    .result_o (ires)
  );

  always_comb begin
    take = 1'b0;
    case (cur_q.cmd)
      CMD_JB:  take = $signed(a_val) <  $signed(b_q);
      CMD_JA:  take = $signed(a_val) >  $signed(b_q);
      CMD_JBE: take = $signed(a_val) <= $signed(b_q);
      CMD_JAE: take = $signed(a_val) >= $signed(b_q);
      CMD_JE:  take = (a_val == b_q);
      default: take = 1'b0;
    endcase
  end

  // Datapath and state updates of the execute and iterate states.
  always_comb begin
    st        = ST_OK;
    nip       = nip1;
    ov        = 32'd0;
    ovalid    = 1'b0;
    ds_we     = 1'b0;
    ds_waddr  = dep_q[AW-1:0];
    ds_wdata  = 32'd0;
    dep_d     = dep_q;
    rdep_d    = rdep_q;
    rs_we     = 1'b0;
    rf_we     = 1'b0;
    finish    = 1'b0;
    go_iter   = 1'b0;
    ireq.start = 1'b0;
    ireq.op    = IOP_DIV;
    if (state_q == BK_EXEC) begin
      finish = 1'b1;
      case (cur_q.cmd)
        CMD_PUSH, CMD_IN: begin
          if (dep_q == DW'(DATA_STACK_DEPTH)) begin
            st = ST_OVER;
          end else begin
            ds_we    = 1'b1;
            ds_wdata = (cur_q.cmd == CMD_PUSH) ? cur_q.arg : cur_q.inv;
            dep_d    = dep_q + DW'(1);
            nip      = (cur_q.cmd == CMD_PUSH) ? nip2 : nip1;
          end
        end
        CMD_POP, CMD_OUT: begin
          if (dep_q == DW'(0)) begin
            st = ST_UNDER;
          end else begin
            dep_d  = dm1;
            ov     = (cur_q.cmd == CMD_OUT) ? b_q : 32'd0;
            ovalid = (cur_q.cmd == CMD_OUT);
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL: begin
          if (dep_q < DW'(2)) begin
            st = ST_UNDER;
          end else begin
            ds_we    = 1'b1;
            ds_waddr = dm2[AW-1:0];
            dep_d    = dm1;
            case (cur_q.cmd)
              CMD_ADD: ds_wdata = a_val + b_q;
              CMD_SUB: ds_wdata = a_val - b_q;
              default: ds_wdata = a_val * b_q;
            endcase
          end
        end
        CMD_DIV, CMD_POW: begin
          if (dep_q < DW'(2)) begin
            st = ST_UNDER;
          end else if ((cur_q.cmd == CMD_DIV) && (b_q == 32'd0)) begin
            st = ST_DIVZ;
          end else begin
            finish     = 1'b0;
            go_iter    = 1'b1;
            ireq.start = 1'b1;
            ireq.op    = (cur_q.cmd == CMD_DIV) ? IOP_DIV : IOP_POW;
          end
        end
        CMD_SQRT: begin
          if (dep_q == DW'(0)) begin
            st = ST_UNDER;
          end else if (b_q[31]) begin
            st = ST_NEGSQ;
          end else begin
            finish     = 1'b0;
            go_iter    = 1'b1;
            ireq.start = 1'b1;
            ireq.op    = IOP_SQRT;
          end
        end
        CMD_PUSHR: begin
          if (!reg_ok) begin
            st = ST_BADREG;
          end else if (dep_q == DW'(DATA_STACK_DEPTH)) begin
            st = ST_OVER;
          end else begin
            ds_we    = 1'b1;
            ds_wdata = reg_val;
            dep_d    = dep_q + DW'(1);
            nip      = nip2;
          end
        end
        CMD_POPR: begin
          if (!reg_ok) begin
            st = ST_BADREG;
          end else if (dep_q == DW'(0)) begin
            st = ST_UNDER;
          end else begin
            rf_we = 1'b1;
            dep_d = dm1;
            nip   = nip2;
          end
        end
        CMD_JMP: begin
          if (!tgt_ok) begin
            st = ST_BADTGT;
          end else begin
            nip = cur_q.arg[CAB-1:0];
          end
        end
        CMD_JB, CMD_JA, CMD_JBE, CMD_JAE, CMD_JE: begin
          if (dep_q < DW'(2)) begin
            st = ST_UNDER;
          end else if (take && !tgt_ok) begin
            st = ST_BADTGT;
          end else begin
            dep_d = dm2;
            nip   = take ? cur_q.arg[CAB-1:0] : nip2;
          end
        end
        CMD_CALL: begin
          if (rdep_q == RDW'(RETURN_STACK_DEPTH)) begin
            st = ST_RSTK;
          end else if (!tgt_ok) begin
            st = ST_BADTGT;
          end else begin
            rs_we  = 1'b1;
            rdep_d = rdep_q + RDW'(1);
            nip    = cur_q.arg[CAB-1:0];
          end
        end
        CMD_RET: begin
          if (rdep_q == RDW'(0)) begin
            st = ST_RSTK;
          end else begin
            rdep_d = rdm1;
            nip    = rs_rdata_q;
          end
        end
        default: begin
          nip = nip1;
        end
      endcase
    end else if ((state_q == BK_ITER) && idone) begin
      finish   = 1'b1;
      ds_we    = 1'b1;
      ds_wdata = ires;
      if (cur_q.cmd == CMD_SQRT) begin
        ds_waddr = dm1[AW-1:0];
      end else begin
        ds_waddr = dm2[AW-1:0];
        dep_d    = dm1;
      end
    end
    // A fault leaves every piece of state as it was.
    if (st != ST_OK) begin
      ds_we  = 1'b0;
      rs_we  = 1'b0;
      rf_we  = 1'b0;
      dep_d  = dep_q;
      rdep_d = rdep_q;
      nip    = ip_q;
      ov     = 32'd0;
      ovalid = 1'b0;
    end
    ip_d = finish ? nip : ip_q;
    ipx  = {16'd0, ip_d};
    res_d.next_ip   = ipx[15:0];
    res_d.out_value = ov;
    res_d.out_valid = ovalid;
    res_d.status    = st;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = BK_RDA;
        end
      end
      BK_RDA: begin
        state_d = BK_EXEC;
      end
      BK_EXEC: begin
        state_d = go_iter ? BK_ITER : BK_WB;
      end
      BK_ITER: begin
        if (idone) begin
          state_d = BK_WB;
        end
      end
      BK_WB: begin
        if (!out_vld_q || out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      ip_q      <= '0;
      dep_q     <= '0;
      rdep_q    <= '0;
      rf_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ip_q    <= ip_d;
      dep_q   <= dep_d;
      rdep_q  <= rdep_d;
      if (rf_we) begin
        rf_vld_q[rf_idx] <= 1'b1;
      end
      if ((state_q == BK_WB) && (!out_vld_q || out_ready_i)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (state_q == BK_RDA) begin
      b_q <= ds_rdata_q;
    end
    if (finish) begin
      res_q <= res_d;
    end
    if ((state_q == BK_WB) && (!out_vld_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  // Data stack: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ds_we) begin
      ds_mem[ds_waddr] <= ds_wdata;
    end
    ds_rdata_q <= ds_mem[ds_raddr];
  end

  // Return stack: the top entry is read every cycle.
  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rdep_q[RAW-1:0]] <= nip2;
    end
    rs_rdata_q <= rs_mem[rdm1[RAW-1:0]];
  end

  // Register file: entries never written read as zero through the valid bits.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_idx] <= b_q;
    end
    rf_rdata_q <= rf_mem[rf_idx];
    rf_rvld_q  <= rf_vld_q[rf_idx];
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one stack machine instruction per item and reports next address.
// ----------------------------------------------------------------------------
// Each input item is one decoded instruction; each produces exactly one result
// item with the next instruction address, an output value for out and a
// status code. A two-entry queue at the front takes items while the back end
// is busy, so the upstream side only stalls once two items are waiting. The
// back end works on one item at a time: simple commands (push, pop, add, sub,
// mul, in, out, register moves, jumps, call, ret) pass the idle, read, execute
// and write-back states from the queue to the output register; the read state
// fetches the second stack entry from the data stack memory. Divide adds an
// iterate state for its bit-serial restoring divider, power iterates with
// square-and-multiply and square root iterates too, and no new item leaves
// the queue meanwhile. A finished result waits in the output register
// while the queue keeps filling. Register file entries read as zero until
// written; the data and return stacks need no clearing because only entries
// below the current depth are ever read. Faulting instructions change no
// state and report the current instruction address.
`default_nettype none

module stack_machine_execute_unit import smx_pkg::*; #(
  parameter int DATA_STACK_DEPTH   = 64,
  parameter int RETURN_STACK_DEPTH = 16,
  parameter int NUM_REGS           = 8,
  parameter int CODE_ADDR_BITS     = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire smx_in_t in_item_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output smx_out_t     out_item_o
);

  // Queue between the front end and the back end.
  logic     q_valid;
  smx_dec_t q_item;
  logic     q_pop;

  smx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  smx_back #(
    .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
    .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
    .NUM_REGS           (NUM_REGS),
    .CODE_ADDR_BITS     (CODE_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/smx_checker.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_machine_execute_unit_defines.svh"

module smx_checker import smx_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire smx_out_t out_item_o
);

  // A result that is held back stays offered and unchanged.
  `SMX_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `SMX_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_item_o))
  // Only a successful out command carries an output value.
  `SMX_ASSERT_NOW(a_flag_ok, out_valid_o && out_item_o.out_valid,
                  out_item_o.status == ST_OK)
  `SMX_ASSERT_NOW(a_fault_zero, out_valid_o && (out_item_o.status != ST_OK),
                  (out_item_o.out_value == 32'sd0) && !out_item_o.out_valid)

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (.*);

`default_nettype wire

// ===== tb/tb_stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Drives decoded instructions into the execute unit and checks every result
// item against a behavioral model of the stack machine kept in this file.
// ----------------------------------------------------------------------------
// A directed sequence covers the faults and the corner cases of arithmetic,
// registers, jumps, call and ret. A long random program follows, biased so
// that the stacks stay mostly in range while still reaching overflow,
// underflow and the other faults. Both sides idle at random, the receiver
// holds off once for a long stretch, and the sender pauses once until the
// block has drained.

module tb_stack_machine_execute_unit;
  import smx_pkg::*;

  localparam int DataDepth   = 64;
  localparam int RetDepth    = 16;
  localparam int NumRegs     = 8;
  localparam int RandomItems = 1070;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  smx_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  smx_out_t out_item;

  stack_machine_execute_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Machine state as the block should hold it.
  logic [15:0] pc;
  logic [31:0] dstk [DataDepth];
  int          dsp;
  logic [15:0] rstk [RetDepth];
  int          rsp;
  logic [31:0] regs [NumRegs];

  smx_out_t pending_results[$];
  int       errors;
  bit       calm;      // no idling on either side
  int       hold_off;  // receiver stall length requested by a test

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] r, bitv;
    r = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] int_pow(logic [31:0] base, logic [31:0] ex);
    logic [31:0] r;
    r = 1;
    if ($signed(ex) <= 0) return 1;
    while (ex != 0) begin
      if (ex[0]) r = r * base;
      base = base * base;
      ex >>= 1;
    end
    return r;
  endfunction

  // Executes one instruction on the model state and returns its result.
  function automatic smx_out_t execute(smx_in_t it);
    logic [31:0] a, b, arg, r;
    logic [15:0] nip;
    logic        tgt_ok, take;
    status_e     st;
    smx_out_t    res;
    a = 0;
    b = 0;
    r = 0;
    arg = it.argument;
    nip = pc + 16'd1;
    tgt_ok = (arg[31:16] == 16'd0);
    st = ST_OK;
    res = '0;
    if (dsp >= 1) b = dstk[dsp-1];
    if (dsp >= 2) a = dstk[dsp-2];
    case (cmd_e'(it.command))
      CMD_PUSH, CMD_IN: begin
        if (dsp >= DataDepth) st = ST_OVER;
        else begin
          dstk[dsp] = (it.command == CMD_PUSH) ? arg : it.in_value;
          dsp++;
          if (it.command == CMD_PUSH) nip = pc + 16'd2;
        end
      end
      CMD_POP, CMD_OUT: begin
        if (dsp < 1) st = ST_UNDER;
        else begin
          dsp--;
          if (it.command == CMD_OUT) begin
            res.out_value = b;
            res.out_valid = 1'b1;
          end
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW: begin
        if (dsp < 2) st = ST_UNDER;
        else if (it.command == CMD_DIV && b == 0) st = ST_DIVZ;
        else begin
          case (cmd_e'(it.command))
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_MUL: r = a * b;
            CMD_DIV: begin
              // The most negative number over minus one wraps to itself.
              if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
              else r = $signed(a) / $signed(b);
            end
            default: r = int_pow(a, b);
          endcase
          dsp--;
          dstk[dsp-1] = r;
        end
      end
      CMD_SQRT: begin
        if (dsp < 1) st = ST_UNDER;
        else if (b[31]) st = ST_NEGSQ;
        else dstk[dsp-1] = int_sqrt(b);
      end
      CMD_PUSHR: begin
        // The register index is checked ahead of the stack.
        if (arg >= NumRegs) st = ST_BADREG;
        else if (dsp >= DataDepth) st = ST_OVER;
        else begin
          dstk[dsp] = regs[arg];
          dsp++;
          nip = pc + 16'd2;
        end
      end
      CMD_POPR: begin
        if (arg >= NumRegs) st = ST_BADREG;
        else if (dsp < 1) st = ST_UNDER;
        else begin
          regs[arg] = b;
          dsp--;
          nip = pc + 16'd2;
        end
      end
      CMD_JMP: begin
        if (!tgt_ok) st = ST_BADTGT;
        else nip = arg[15:0];
      end
      CMD_JB, CMD_JA, CMD_JBE, CMD_JAE, CMD_JE: begin
        if (dsp < 2) st = ST_UNDER;
        else begin
          case (cmd_e'(it.command))
            CMD_JB:  take = $signed(a) < $signed(b);
            CMD_JA:  take = $signed(a) > $signed(b);
            CMD_JBE: take = $signed(a) <= $signed(b);
            CMD_JAE: take = $signed(a) >= $signed(b);
            default: take = (a == b);
          endcase
          // A jump not taken ignores its target but still pops both.
          if (take && !tgt_ok) st = ST_BADTGT;
          else begin
            dsp -= 2;
            nip = take ? arg[15:0] : pc + 16'd2;
          end
        end
      end
      CMD_CALL: begin
        if (rsp >= RetDepth) st = ST_RSTK;
        else if (!tgt_ok) st = ST_BADTGT;
        else begin
          rstk[rsp] = pc + 16'd2;
          rsp++;
          nip = arg[15:0];
        end
      end
      CMD_RET: begin
        if (rsp < 1) st = ST_RSTK;
        else begin
          rsp--;
          nip = rstk[rsp];
        end
      end
      default: ;  // unknown commands are one-word no-ops
    endcase
    if (st != ST_OK) begin
      nip = pc;
      res.out_value = 0;
      res.out_valid = 1'b0;
    end
    pc = nip;
    res.next_ip = nip;
    res.status = st;
    return res;
  endfunction

  // Offers one instruction item and records its expected result on accept.
  task automatic send_instr(cmd_e c, logic [31:0] arg = 0, logic [31:0] inv = 0);
    smx_in_t it;
    it = '{command: c, argument: arg, in_value: inv};
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(execute(it));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 0;
      4: return $urandom_range(20);
      5: return -$urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, with one long hold-off when a test asks for it.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, exp_v, act_v);
  endtask

  // Checks each accepted result against the oldest expected one.
  always @(posedge clk_i) begin
    smx_out_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, out_item.next_ip);
      end else begin
        e = pending_results.pop_front();
        if (out_item.next_ip !== e.next_ip) report("next_ip", e.next_ip, out_item.next_ip);
        if (out_item.out_value !== e.out_value)
          report("out_value", e.out_value, out_item.out_value);
        if (out_item.out_valid !== e.out_valid)
          report("out_valid", e.out_valid, out_item.out_valid);
        if (out_item.status !== e.status) report("status", e.status, out_item.status);
      end
    end
  end

  // Faults on an empty machine, arithmetic extremes, registers, control flow.
  task automatic test_directed();
    send_instr(CMD_POP);
    send_instr(CMD_RET);
    send_instr(CMD_ADD);
    send_instr(CMD_PUSH, 32'h8000_0000);
    send_instr(CMD_PUSH, 32'hFFFF_FFFF);
    send_instr(CMD_DIV);
    send_instr(CMD_SQRT);
    send_instr(CMD_PUSH, 0);
    send_instr(CMD_DIV);
    send_instr(CMD_POW);
    send_instr(CMD_IN, 0, 32'h7FFF_FFFF);
    send_instr(CMD_SQRT);
    send_instr(CMD_OUT);
    send_instr(CMD_PUSHR, NumRegs);
    send_instr(CMD_POPR, 32'hFFFF_FFFF);
    send_instr(CMD_POPR, NumRegs - 1);
    send_instr(CMD_PUSHR, NumRegs - 1);
    send_instr(CMD_JMP, 32'h0001_0000);
    send_instr(CMD_JMP, 32'h0000_FFFF);
    send_instr(CMD_PUSH, 1);
    send_instr(CMD_JAE, 32'h8000_0000);
    send_instr(CMD_CALL, 32'h0000_FFFE);
    send_instr(CMD_RET);
    send_instr(cmd_e'(5'd31), $urandom, $urandom);
    send_instr(CMD_JE, 32'hFFFF_FFFF);
  endtask

  // Random program, mostly well formed, with bursts that fill the stacks.
  task automatic test_random(int n);
    cmd_e        c;
    logic [31:0] arg;
    int          k;
    for (int i = 0; i < n; i++) begin
      calm = (i < 300);
      k = $urandom_range(99);
      if ($urandom_range(199) == 0) begin
        for (int j = 0; j < DataDepth + 2; j++) send_instr(CMD_PUSH, rand_word());
        continue;
      end
      if ($urandom_range(199) == 0) begin
        for (int j = 0; j < RetDepth + 2; j++) send_instr(CMD_CALL, $urandom_range(65535));
        continue;
      end
      if (dsp < 3 && k < 60) c = (k < 25) ? CMD_PUSH : (k < 45) ? CMD_IN : CMD_PUSHR;
      else if (dsp > DataDepth - 4 && k < 50) c = cmd_e'($urandom_range(1, 7));
      else if (k < 5) c = cmd_e'($urandom_range(20, 31));
      else c = cmd_e'($urandom_range(19));
      case (c)
        CMD_PUSHR, CMD_POPR:
          arg = ($urandom_range(99) < 85) ? $urandom_range(NumRegs - 1) : rand_word();
        CMD_JMP, CMD_JB, CMD_JA, CMD_JBE, CMD_JAE, CMD_JE, CMD_CALL:
          arg = ($urandom_range(99) < 85) ? $urandom_range(65535) : rand_word();
        default: arg = ($urandom_range(1)) ? rand_word() : $urandom;
      endcase
      send_instr(c, arg, rand_word());
    end
    calm = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, then drain fully.
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 12; i++) send_instr(CMD_PUSH, $urandom);
    wait_drained();
    for (int i = 0; i < 12; i++) send_instr(CMD_POP);
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    hold_off = 0;
    pc = 0;
    dsp = 0;
    rsp = 0;
    foreach (regs[i]) regs[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(RandomItems);
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== stack_machine_execute_unit.f =====
+incdir+rtl
rtl/smx_pkg.sv
rtl/smx_front.sv
rtl/smx_iter.sv
rtl/smx_back.sv
rtl/stack_machine_execute_unit.sv
rtl/smx_checker.sv
tb/tb_stack_machine_execute_unit.sv
